/* src/autoranging_adc_averager_macros.svh */
// Assertion macros used by the module that carries checks.
`ifndef AUTORANGING_ADC_AVERAGER_MACROS_SVH
`define AUTORANGING_ADC_AVERAGER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ARAVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aravg check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ARAVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aravg check failed");

`endif

/* src/aravg_pkg.sv */
`timescale 1ns / 1ps

package aravg_pkg;

  localparam int NUM_GAINS_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int ACC_W      = 32;
  localparam int THR_W      = 24;
  localparam int SHIFT_W    = 4;
  localparam int LIMIT_W    = 4;
  localparam int CNT_W      = 9;
  localparam int AVG_W      = 24;
  localparam int KIND_W     = 2;
  localparam int GIDX_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;

  localparam logic [KIND_W-1:0] EV_AVERAGE   = 2'd0;
  localparam logic [KIND_W-1:0] EV_GAIN_DOWN = 2'd1;
  localparam logic [KIND_W-1:0] EV_GAIN_UP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_LIM = 2'd3;

  localparam logic [THR_W-1:0]   HIGH_THR_RST  = 24'd15099494;
  localparam logic [THR_W-1:0]   LOW_THR_RST   = 24'd167772;
  localparam logic [SHIFT_W-1:0] AVG_SHIFT_RST = 4'd4;
  localparam logic [LIMIT_W-1:0] STRIKE_LIM_RST = 4'd2;

  typedef struct packed {
    logic [THR_W-1:0]   high_thr;
    logic [THR_W-1:0]   low_thr;
    logic [SHIFT_W-1:0] avg_shift;
    logic [LIMIT_W-1:0] strike_lim;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              channel;
    logic [AVG_W-1:0]  average;
    logic [GIDX_W-1:0] gain;
  } event_t;

endpackage

/* src/aravg_cfg.sv */
`timescale 1ns / 1ps

module aravg_cfg
  import aravg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_HIGH_THR:   cfg_nxt.high_thr   = wr_data[THR_W-1:0];
        REG_LOW_THR:    cfg_nxt.low_thr    = wr_data[THR_W-1:0];
        REG_AVG_SHIFT:  cfg_nxt.avg_shift  = wr_data[SHIFT_W-1:0];
        REG_STRIKE_LIM: cfg_nxt.strike_lim = wr_data[LIMIT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_thr   <= HIGH_THR_RST;
      cfg_r.low_thr    <= LOW_THR_RST;
      cfg_r.avg_shift  <= AVG_SHIFT_RST;
      cfg_r.strike_lim <= STRIKE_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/aravg_core.sv */
`timescale 1ns / 1ps

module aravg_core
  import aravg_pkg::*;
#(
  parameter int NUM_GAINS   = NUM_GAINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cfg_t                   cfg,
  output event_t                 ev
);

  localparam int GAIN_W = $clog2(NUM_GAINS);
  localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(NUM_GAINS - 1);

  logic               active_r, active_nxt;
  logic [GAIN_W-1:0]  gain_r [2];
  logic [GAIN_W-1:0]  gain_nxt;
  logic [LIMIT_W-1:0] high_strk_r, high_strk_nxt;
  logic [LIMIT_W-1:0] low_strk_r, low_strk_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [GAIN_W-1:0]        g;
  logic [SHIFT_W-1:0]       shift;
  logic [ACC_W-1:0]         s_ext;
  logic [ACC_W-1:0]         acc_sum;
  logic [ACC_W-1:0]         avg_full;
  logic [CNT_W-1:0]         cnt_inc;
  logic [CNT_W-1:0]         block_len;
  logic [LIMIT_W:0]         high_inc;
  logic [LIMIT_W:0]         low_inc;
  logic                     high_hit, low_hit;
  logic                     step_down, step_up, block_done;
  logic [GAIN_W+GIDX_W-1:0] gain_ext;

  always_comb begin
    g         = gain_r[active_r];
    shift     = (cfg.avg_shift > MAX_SHIFT) ? MAX_SHIFT : cfg.avg_shift;
    s_ext     = ACC_W'(sample);
    acc_sum   = acc_r + s_ext;
    avg_full  = acc_sum >> shift;
    cnt_inc   = cnt_r + CNT_W'(1);
    block_len = CNT_W'(1) << shift;
    high_inc  = {1'b0, high_strk_r} + (LIMIT_W + 1)'(1);
    low_inc   = {1'b0, low_strk_r} + (LIMIT_W + 1)'(1);

    high_hit  = (g != '0) && (s_ext > ACC_W'(cfg.high_thr));
    low_hit   = !high_hit && (g != GAIN_MAX) && (s_ext < ACC_W'(cfg.low_thr));
    step_down = high_hit && (high_inc > {1'b0, cfg.strike_lim});
    step_up   = low_hit && (low_inc > {1'b0, cfg.strike_lim});
    block_done = !high_hit && !low_hit && (cnt_inc >= block_len);

    active_nxt    = active_r;
    gain_nxt      = g;
    high_strk_nxt = high_strk_r;
    low_strk_nxt  = low_strk_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;

    if (step_down || step_up || block_done) begin
      high_strk_nxt = '0;
      low_strk_nxt  = '0;
      acc_nxt       = '0;
      cnt_nxt       = '0;
      if (step_down) begin
        gain_nxt = g - GAIN_W'(1);
      end else if (step_up) begin
        gain_nxt = g + GAIN_W'(1);
      end else begin
        active_nxt = !active_r;
      end
    end else if (high_hit) begin
      high_strk_nxt = high_inc[LIMIT_W-1:0];
    end else if (low_hit) begin
      low_strk_nxt = low_inc[LIMIT_W-1:0];
    end else begin
      acc_nxt = acc_sum;
      cnt_nxt = cnt_inc;
    end

    gain_ext   = (GAIN_W + GIDX_W)'(gain_nxt);
    ev.valid   = step_down || step_up || block_done;
    ev.kind    = step_down ? EV_GAIN_DOWN : (step_up ? EV_GAIN_UP : EV_AVERAGE);
    ev.channel = active_r;
    ev.average = block_done ? avg_full[AVG_W-1:0] : '0;
    ev.gain    = gain_ext[GIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      gain_r[0]   <= '0;
      gain_r[1]   <= '0;
      high_strk_r <= '0;
      low_strk_r  <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else if (fire) begin
      active_r         <= active_nxt;
      gain_r[active_r] <= gain_nxt;
      high_strk_r      <= high_strk_nxt;
      low_strk_r       <= low_strk_nxt;
      acc_r            <= acc_nxt;
      cnt_r            <= cnt_nxt;
    end
  end

endmodule

/* src/autoranging_adc_averager.sv */
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall    in_sample
// out_     output     out_valid/out_stall  out_event_kind, out_channel, out_average,
//                                          out_gain_index
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample is accepted per cycle while in_stall is low; it is registered,
// then classified and folded into the channel state once the output register
// can take a result, and any event it raises is registered there.
// Reset is synchronous on rst_n and restores the configuration, the channel
// state and the valid flags.
// A stalled result holds the output register and then the sample register;
// in_stall rises only when both are full.
`timescale 1ns / 1ps
`include "autoranging_adc_averager_macros.svh"

module autoranging_adc_averager
  import aravg_pkg::*;
#(
  parameter int NUM_GAINS   = NUM_GAINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      out_event_kind,
  output logic                   out_channel,
  output logic [AVG_W-1:0]       out_average,
  output logic [GIDX_W-1:0]      out_gain_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t   cfg;
  event_t ev;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r, out_valid_nxt;
  event_t                 out_r;
  logic                   fire;
  logic                   in_take;

  assign cfg_ready = 1'b1;

  aravg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  aravg_core #(
    .NUM_GAINS   (NUM_GAINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .ev     (ev)
  );

  always_comb begin
    fire     = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall = s1_valid_r && !fire;
    in_take  = in_valid && !in_stall;

    s1_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

    if (fire) begin
      out_valid_nxt = ev.valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
    end
    if (fire && ev.valid) begin
      out_r <= ev;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_r.kind;
  assign out_channel    = out_r.channel;
  assign out_average    = out_r.average;
  assign out_gain_index = out_r.gain;

  `ARAVG_ASSERT_NOW(a_stall_needs_sample, in_stall, s1_valid_r)
  `ARAVG_ASSERT_NOW(a_step_has_no_average, out_valid && (out_event_kind != EV_AVERAGE), out_average == '0)
  `ARAVG_ASSERT_NEXT(a_fire_sets_output, fire, out_valid_r == $past(ev.valid))

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import aravg_pkg::*;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic              channel;
    logic [AVG_W-1:0]  average;
    logic [GIDX_W-1:0] gain;
  } range_event_t;

  // Tracks the gain of both channels and the block state of the active one, and predicts each event.
  class autorange_scoreboard;
    logic [THR_W-1:0]   high_thr = HIGH_THR_RST;
    logic [THR_W-1:0]   low_thr = LOW_THR_RST;
    logic [SHIFT_W-1:0] avg_shift = AVG_SHIFT_RST;
    logic [LIMIT_W-1:0] strike_lim = STRIKE_LIM_RST;
    logic               active_ch = 1'b0;
    logic [GIDX_W-1:0]  gain_of[2] = '{2'd0, 2'd0};
    int unsigned        high_hits = 0;
    int unsigned        low_hits = 0;
    logic [ACC_W-1:0]   sum = '0;
    int unsigned        taken = 0;
    range_event_t       pending_events[$];
    int                 errors = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HIGH_THR: high_thr = data;
        REG_LOW_THR: low_thr = data;
        REG_AVG_SHIFT: avg_shift = data[SHIFT_W-1:0];
        REG_STRIKE_LIM: strike_lim = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void restart_block();
      high_hits = 0;
      low_hits = 0;
      sum = '0;
      taken = 0;
    endfunction

    function void add_event(logic [KIND_W-1:0] kind, logic ch, logic [AVG_W-1:0] avg);
      range_event_t ev;
      ev.kind = kind;
      ev.channel = ch;
      ev.average = avg;
      ev.gain = gain_of[ch];
      pending_events.push_back(ev);
    endfunction

    function void note_sample(logic [SAMPLE_BITS_DEF-1:0] s);
      logic               ch;
      logic [GIDX_W-1:0]  g;
      logic [SHIFT_W-1:0] sh;
      logic [ACC_W-1:0]   shifted;
      ch = active_ch;
      g = gain_of[ch];
      sh = (avg_shift > MAX_SHIFT) ? MAX_SHIFT : avg_shift;
      if (g > 0 && s > high_thr) begin
        if (high_hits + 1 > strike_lim) begin
          gain_of[ch] = g - 1'b1;
          restart_block();
          add_event(EV_GAIN_DOWN, ch, '0);
        end else begin
          high_hits++;
        end
      end else if (g < NUM_GAINS_DEF - 1 && s < low_thr) begin
        if (low_hits + 1 > strike_lim) begin
          gain_of[ch] = g + 1'b1;
          restart_block();
          add_event(EV_GAIN_UP, ch, '0);
        end else begin
          low_hits++;
        end
      end else begin
        sum = sum + s;
        taken++;
        if (taken >= (1 << sh)) begin
          shifted = sum >> sh;
          add_event(EV_AVERAGE, ch, shifted[AVG_W-1:0]);
          active_ch = ~ch;
          restart_block();
        end
      end
    endfunction

    function void check_event(logic [KIND_W-1:0] kind, logic ch, logic [AVG_W-1:0] avg,
                              logic [GIDX_W-1:0] gain);
      range_event_t ev;
      if (pending_events.size() == 0) begin
        $error("event with nothing expected: kind %0d channel %0d", kind, ch);
        errors++;
      end else begin
        ev = pending_events.pop_front();
        if (kind !== ev.kind) begin
          $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
          errors++;
        end
        if (ch !== ev.channel) begin
          $error("channel: expected %0d, actual %0d", ev.channel, ch);
          errors++;
        end
        if (avg !== ev.average) begin
          $error("average: expected %0h, actual %0h", ev.average, avg);
          errors++;
        end
        if (gain !== ev.gain) begin
          $error("gain_index: expected %0d, actual %0d", ev.gain, gain);
          errors++;
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [SAMPLE_BITS_DEF-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic [KIND_W-1:0]          out_event_kind;
  logic                       out_channel;
  logic [AVG_W-1:0]           out_average;
  logic [GIDX_W-1:0]          out_gain_index;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  autorange_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  logic [23:0] directed_a[7] = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000,
                                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
  logic [23:0] directed_b[11] = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
                                  24'h000000, 24'h000000, 24'hFFFFFF, 24'h800000,
                                  24'h000100, 24'h7FFFFF, 24'h000100};

  autoranging_adc_averager u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_kind(out_event_kind),
    .out_channel(out_channel),
    .out_average(out_average),
    .out_gain_index(out_gain_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_event(out_event_kind, out_channel, out_average, out_gain_index);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [23:0] pick_sample(logic [23:0] hi, logic [23:0] lo);
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) begin
      return ($urandom_range(1, 0) != 0) ? 24'hFFFFFF : 24'h000000;
    end else if (r < 25 && hi != 24'hFFFFFF) begin
      return 24'($urandom_range(24'hFFFFFF, hi + 1));
    end else if (r < 40 && lo != 24'h000000) begin
      return 24'($urandom_range(lo - 1, 0));
    end
    return 24'($urandom & 24'hFFFFFF);
  endfunction

  task automatic push_sample(logic [23:0] s);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
  endtask

  // Holds the input until every predicted event has been taken, then lets
  // the pipeline settle on any transaction that produces no event.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  task automatic configure(logic [23:0] hi, logic [23:0] lo, logic [3:0] sh, logic [3:0] lim);
    drain();
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_AVG_SHIFT, {20'd0, sh});
    write_reg(REG_STRIKE_LIM, {20'd0, lim});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n, logic [23:0] hi, logic [23:0] lo, logic [3:0] sh,
                           logic [3:0] lim);
    configure(hi, lo, sh, lim);
    for (int i = 0; i < n; i++) begin
      push_sample(pick_sample(hi, lo));
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_HIGH_THR;
    cfg_data = '0;
    quiet_cycles = 0;
    send_idle_pct = 15;
    recv_idle_pct = 54;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_a[i]) push_sample(directed_a[i]);
    configure(24'h800000, 24'h000100, 4'd1, 4'd0);
    foreach (directed_b[i]) push_sample(directed_b[i]);

    run_phase(100, 24'($urandom_range(24'hFFFFFF, 24'h800000)),
              24'($urandom_range(24'h400000, 0)), 4'd2, 4'd1);
    run_phase(40, 24'hFFFFFF, 24'h000000, 4'd0, 4'd15);

    send_idle_pct = 54;
    recv_idle_pct = 15;
    run_phase(60, 24'h000000, 24'hFFFFFF, 4'd3, 4'd0);
    run_phase(80, 24'($urandom_range(24'hFFFFFF, 24'h800000)),
              24'($urandom_range(24'h400000, 0)), 4'd1, 4'd2);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(256, 24'hFFFFFF, 24'h000000, 4'd15, 4'd4);
    run_phase(40, 24'($urandom_range(24'hFFFFFF, 24'h800000)),
              24'($urandom_range(24'h400000, 0)), 4'd2, 4'd2);

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/aravg_pkg.sv
src/aravg_cfg.sv
src/aravg_core.sv
src/autoranging_adc_averager.sv
dv/testbench.sv
